>>> sv/risc16_instruction_step_assert.svh
// ----------------------------------------------------------------------------
// risc16_instruction_step_assert.svh
// Assertion macros shared by the processor RTL. Every macro is clocked on
// clock and stays off while reset is high.
// ----------------------------------------------------------------------------
`ifndef RISC16_INSTRUCTION_STEP_ASSERT_SVH
`define RISC16_INSTRUCTION_STEP_ASSERT_SVH

// Same-cycle implication
`define R16_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define R16_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/r16_step_pkg.sv
// ----------------------------------------------------------------------------
// r16_step_pkg
// Opcodes, memory size and shared constants of the 16-bit processor step.
// ----------------------------------------------------------------------------
package r16_step_pkg;

   // Byte memory size
   localparam int MEM_ADDR_BITS = 16;
   localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;
   localparam logic [MEM_ADDR_BITS-1:0] MEM_LAST = '1;

   typedef logic [4:0] opcode_type;

   localparam opcode_type OP_MV    = 5'h00;
   localparam opcode_type OP_ADD   = 5'h01;
   localparam opcode_type OP_SUB   = 5'h02;
   localparam opcode_type OP_CMP   = 5'h03;
   localparam opcode_type OP_LD    = 5'h04;
   localparam opcode_type OP_ST    = 5'h05;
   localparam opcode_type OP_JR    = 5'h08;
   localparam opcode_type OP_JZR   = 5'h09;
   localparam opcode_type OP_JNR   = 5'h0A;
   localparam opcode_type OP_CALLR = 5'h0C;
   localparam opcode_type OP_MVI   = 5'h10;
   localparam opcode_type OP_ADDI  = 5'h11;
   localparam opcode_type OP_SUBI  = 5'h12;
   localparam opcode_type OP_CMPI  = 5'h13;
   localparam opcode_type OP_MVHI  = 5'h16;
   localparam opcode_type OP_J     = 5'h18;
   localparam opcode_type OP_JZ    = 5'h19;
   localparam opcode_type OP_JN    = 5'h1A;
   localparam opcode_type OP_CALL  = 5'h1C;

   // Calls link through this register
   localparam logic [2:0] LINK_REG = 3'd7;

   // Item kinds on req_mode
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_EXEC = 1'b1;

endpackage

>>> sv/risc16_instruction_step.sv
// ----------------------------------------------------------------------------
// risc16_instruction_step
// Small 16-bit processor stepped one item at a time: a load item writes a
// word into the byte memory, an execute item fetches and runs one
// instruction. A single 16-bit adder is shared by all address and ALU work.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | mode, load_addr, load_word
//  rsp     | out       | rsp_valid/rsp_stall | next_pc, opcode, register and
//          |           |                     | memory writes, flags, halted
//
//  Load item: WR_LO_ST, WR_HI_ST. Execute item: FETCH_HI_ST, DECODE_ST,
//  EXEC_ST, then RD_LO_ST, RD_HI_ST, LD_DONE_ST for LD or WR_LO_ST, WR_HI_ST
//  for ST. Both end in RESP_ST. The single-port byte memory sets this: one
//  byte is read or written per cycle. When the result is taken the block
//  goes back to IDLE_ST for the next item. After reset a clearing pass zeroes
//  memory and registers with req_stall high. rsp_stall only holds the result.
// ----------------------------------------------------------------------------
module risc16_instruction_step
   import r16_step_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [15:0] req_load_addr,
   input  logic [15:0] req_load_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_next_pc,
   output logic [4:0]  rsp_opcode,
   output logic        rsp_reg_written,
   output logic [2:0]  rsp_reg_index,
   output logic [15:0] rsp_reg_value,
   output logic        rsp_mem_written,
   output logic [15:0] rsp_store_addr,
   output logic [15:0] rsp_store_value,
   output logic        rsp_flag_zero,
   output logic        rsp_flag_negative,
   output logic        rsp_halted
);

   typedef enum logic [3:0] {
      CLEAR_ST,
      IDLE_ST,
      FETCH_HI_ST,
      DECODE_ST,
      EXEC_ST,
      RD_LO_ST,
      RD_HI_ST,
      LD_DONE_ST,
      WR_LO_ST,
      WR_HI_ST,
      RESP_ST
   } state_type;

   state_type state_ff;

   // Architectural state
   logic [15:0] pc_ff;
   logic        zero_ff;
   logic        neg_ff;

   // Sequencer datapath
   logic [MEM_ADDR_BITS-1:0] clr_cnt_ff;
   logic [7:0]  instr_lo_ff;
   logic [7:0]  instr_hi_ff;
   logic [15:0] pc_plus2_ff;
   logic [15:0] addr_ff;
   logic [15:0] data_ff;
   logic [7:0]  ld_lo_ff;

   // Result registers
   logic [4:0]  rsp_opcode_ff;
   logic        rsp_reg_written_ff;
   logic [2:0]  rsp_reg_index_ff;
   logic [15:0] rsp_reg_value_ff;
   logic        rsp_mem_written_ff;
   logic [15:0] rsp_store_addr_ff;
   logic [15:0] rsp_store_value_ff;
   logic        rsp_halted_ff;

   // Memories
   logic [7:0]  byte_mem_ff [0:MEM_DEPTH-1];
   logic [7:0]  mem_rd_ff;
   logic [15:0] rf_mem_ff [0:7];
   logic [15:0] rx_val_ff;
   logic [15:0] ry_val_ff;

   logic [MEM_ADDR_BITS-1:0] mem_addr;
   logic        mem_we;
   logic [7:0]  mem_wdata;
   logic        rf_we;
   logic [2:0]  rf_waddr;
   logic [15:0] rf_wdata;

   // Decoded fields
   opcode_type  op;
   logic [2:0]  rx_idx;
   logic [15:0] imm8_ext;
   logic [15:0] jump_off;

   // Shared adder
   logic [15:0] add_a;
   logic [15:0] add_b;
   logic        add_cin;
   logic [15:0] add_sum;

   // Execute decisions
   logic        exec_rw;
   logic [2:0]  exec_ridx;
   logic [15:0] exec_rval;
   logic        exec_flags;
   logic [15:0] pc_in;

   logic req_accept;
   logic rsp_accept;

   assign req_stall  = (state_ff != IDLE_ST);
   assign rsp_valid  = (state_ff == RESP_ST);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;

   assign op       = instr_lo_ff[4:0];
   assign rx_idx   = instr_lo_ff[7:5];
   assign imm8_ext = {{8{instr_hi_ff[7]}}, instr_hi_ff};
   // imm11 sign-extended, counted in words
   assign jump_off = {{4{instr_hi_ff[7]}}, instr_hi_ff, instr_lo_ff[7:5], 1'b0};

   // Shared adder operand select
   always_comb begin
      add_a   = pc_ff;
      add_b   = 16'd1;
      add_cin = 1'b0;
      case (state_ff)
         DECODE_ST: begin
            add_b = 16'd2;
         end
         RD_HI_ST, WR_HI_ST: begin
            add_a = addr_ff;
         end
         EXEC_ST: begin
            add_a = rx_val_ff;
            case (op)
               OP_ADD: begin
                  add_b = ry_val_ff;
               end
               OP_SUB, OP_CMP: begin
                  add_b   = ~ry_val_ff;
                  add_cin = 1'b1;
               end
               OP_ADDI: begin
                  add_b = imm8_ext;
               end
               OP_SUBI, OP_CMPI: begin
                  add_b   = ~imm8_ext;
                  add_cin = 1'b1;
               end
               OP_J, OP_JZ, OP_JN, OP_CALL: begin
                  add_a = pc_plus2_ff;
                  add_b = jump_off;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   assign add_sum = add_a + add_b + {15'd0, add_cin};

   // Instruction execute decode
   always_comb begin
      exec_rw    = 1'b0;
      exec_ridx  = 3'd0;
      exec_rval  = 16'd0;
      exec_flags = 1'b0;
      pc_in      = pc_plus2_ff;
      case (op)
         OP_MV: begin
            exec_rw   = 1'b1;
            exec_ridx = rx_idx;
            exec_rval = ry_val_ff;
         end
         OP_ADD, OP_SUB, OP_ADDI, OP_SUBI: begin
            exec_rw    = 1'b1;
            exec_ridx  = rx_idx;
            exec_rval  = add_sum;
            exec_flags = 1'b1;
         end
         OP_CMP, OP_CMPI: begin
            exec_flags = 1'b1;
         end
         OP_MVI: begin
            exec_rw   = 1'b1;
            exec_ridx = rx_idx;
            exec_rval = imm8_ext;
         end
         OP_MVHI: begin
            exec_rw   = 1'b1;
            exec_ridx = rx_idx;
            exec_rval = {instr_hi_ff, rx_val_ff[7:0]};
         end
         OP_JR: begin
            pc_in = rx_val_ff;
         end
         OP_JZR: begin
            if (zero_ff) begin
               pc_in = rx_val_ff;
            end
         end
         OP_JNR: begin
            if (neg_ff) begin
               pc_in = rx_val_ff;
            end
         end
         OP_CALLR: begin
            exec_rw   = 1'b1;
            exec_ridx = LINK_REG;
            exec_rval = pc_plus2_ff;
            pc_in     = rx_val_ff;
         end
         OP_J: begin
            pc_in = add_sum;
         end
         OP_JZ: begin
            if (zero_ff) begin
               pc_in = add_sum;
            end
         end
         OP_JN: begin
            if (neg_ff) begin
               pc_in = add_sum;
            end
         end
         OP_CALL: begin
            exec_rw   = 1'b1;
            exec_ridx = LINK_REG;
            exec_rval = pc_plus2_ff;
            pc_in     = add_sum;
         end
         default: begin
         end
      endcase
   end

   // Byte memory port: address, write enable and data
   always_comb begin
      mem_addr  = pc_ff[MEM_ADDR_BITS-1:0];
      mem_we    = 1'b0;
      mem_wdata = 8'd0;
      case (state_ff)
         CLEAR_ST: begin
            mem_addr = clr_cnt_ff;
            mem_we   = 1'b1;
         end
         FETCH_HI_ST, RD_HI_ST: begin
            mem_addr = add_sum[MEM_ADDR_BITS-1:0];
         end
         RD_LO_ST: begin
            mem_addr = addr_ff[MEM_ADDR_BITS-1:0];
         end
         WR_LO_ST: begin
            mem_addr  = addr_ff[MEM_ADDR_BITS-1:0];
            mem_we    = 1'b1;
            mem_wdata = data_ff[7:0];
         end
         WR_HI_ST: begin
            mem_addr  = add_sum[MEM_ADDR_BITS-1:0];
            mem_we    = 1'b1;
            mem_wdata = data_ff[15:8];
         end
         default: begin
         end
      endcase
   end

   // Register file write port
   always_comb begin
      rf_we    = 1'b0;
      rf_waddr = rx_idx;
      rf_wdata = {mem_rd_ff, ld_lo_ff};
      case (state_ff)
         CLEAR_ST: begin
            rf_we    = 1'b1;
            rf_waddr = clr_cnt_ff[2:0];
            rf_wdata = 16'd0;
         end
         EXEC_ST: begin
            rf_we    = exec_rw;
            rf_waddr = exec_ridx;
            rf_wdata = exec_rval;
         end
         LD_DONE_ST: begin
            rf_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Byte memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         byte_mem_ff[mem_addr] <= mem_wdata;
      end
      mem_rd_ff <= byte_mem_ff[mem_addr];
   end

   // Register file; rx from the low instruction byte, ry from the byte now read
   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem_ff[rf_waddr] <= rf_wdata;
      end
      if (state_ff == DECODE_ST) begin
         rx_val_ff <= rf_mem_ff[rx_idx];
         ry_val_ff <= rf_mem_ff[mem_rd_ff[2:0]];
      end
   end

   // Sequencer, architectural state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= CLEAR_ST;
         clr_cnt_ff <= '0;
         pc_ff      <= 16'd0;
         zero_ff    <= 1'b0;
         neg_ff     <= 1'b0;
      end else begin
         case (state_ff)
            CLEAR_ST: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == MEM_LAST) begin
                  state_ff <= IDLE_ST;
               end
            end
            IDLE_ST: begin
               if (req_accept) begin
                  if (req_mode == MODE_LOAD) begin
                     addr_ff            <= req_load_addr;
                     data_ff            <= req_load_word;
                     rsp_opcode_ff      <= OP_MV;
                     rsp_reg_written_ff <= 1'b0;
                     rsp_reg_index_ff   <= 3'd0;
                     rsp_reg_value_ff   <= 16'd0;
                     rsp_mem_written_ff <= 1'b0;
                     rsp_store_addr_ff  <= 16'd0;
                     rsp_store_value_ff <= 16'd0;
                     rsp_halted_ff      <= 1'b0;
                     state_ff           <= WR_LO_ST;
                  end else begin
                     state_ff <= FETCH_HI_ST;
                  end
               end
            end
            FETCH_HI_ST: begin
               instr_lo_ff <= mem_rd_ff;
               state_ff    <= DECODE_ST;
            end
            DECODE_ST: begin
               instr_hi_ff <= mem_rd_ff;
               pc_plus2_ff <= add_sum;
               state_ff    <= EXEC_ST;
            end
            EXEC_ST: begin
               rsp_opcode_ff      <= op;
               rsp_reg_written_ff <= exec_rw || (op == OP_LD);
               rsp_reg_index_ff   <= (op == OP_LD) ? rx_idx : exec_ridx;
               rsp_reg_value_ff   <= exec_rval;
               rsp_mem_written_ff <= (op == OP_ST);
               rsp_store_addr_ff  <= (op == OP_ST) ?
                                     16'(ry_val_ff[MEM_ADDR_BITS-1:0]) : 16'd0;
               rsp_store_value_ff <= (op == OP_ST) ? rx_val_ff : 16'd0;
               rsp_halted_ff      <= (pc_in == pc_ff);
               pc_ff              <= pc_in;
               addr_ff            <= ry_val_ff;
               data_ff            <= rx_val_ff;
               if (exec_flags) begin
                  zero_ff <= (add_sum == 16'd0);
                  neg_ff  <= add_sum[15];
               end
               if (op == OP_LD) begin
                  state_ff <= RD_LO_ST;
               end else if (op == OP_ST) begin
                  state_ff <= WR_LO_ST;
               end else begin
                  state_ff <= RESP_ST;
               end
            end
            RD_LO_ST: begin
               state_ff <= RD_HI_ST;
            end
            RD_HI_ST: begin
               ld_lo_ff <= mem_rd_ff;
               state_ff <= LD_DONE_ST;
            end
            LD_DONE_ST: begin
               rsp_reg_value_ff <= {mem_rd_ff, ld_lo_ff};
               state_ff         <= RESP_ST;
            end
            WR_LO_ST: begin
               state_ff <= WR_HI_ST;
            end
            WR_HI_ST: begin
               state_ff <= RESP_ST;
            end
            RESP_ST: begin
               if (rsp_accept) begin
                  state_ff <= IDLE_ST;
               end
            end
            default: begin
               state_ff <= IDLE_ST;
            end
         endcase
      end
   end

   assign rsp_next_pc       = pc_ff;
   assign rsp_opcode        = rsp_opcode_ff;
   assign rsp_reg_written   = rsp_reg_written_ff;
   assign rsp_reg_index     = rsp_reg_index_ff;
   assign rsp_reg_value     = rsp_reg_value_ff;
   assign rsp_mem_written   = rsp_mem_written_ff;
   assign rsp_store_addr    = rsp_store_addr_ff;
   assign rsp_store_value   = rsp_store_value_ff;
   assign rsp_flag_zero     = zero_ff;
   assign rsp_flag_negative = neg_ff;
   assign rsp_halted        = rsp_halted_ff;

   // Checks
`include "risc16_instruction_step_assert.svh"

   `R16_ASSERT_NEXT(a_exec_fetches, req_accept && (req_mode == MODE_EXEC), state_ff == FETCH_HI_ST, "execute item did not start its fetch")
   `R16_ASSERT_NEXT(a_load_writes, req_accept && (req_mode == MODE_LOAD), state_ff == WR_LO_ST, "load item did not go to the memory write")
   `R16_ASSERT_NEXT(a_clear_ends, (state_ff == CLEAR_ST) && (clr_cnt_ff == MEM_LAST), state_ff == IDLE_ST, "clearing pass did not end at the last entry")
   `R16_ASSERT_NEXT(a_one_result, rsp_accept, !rsp_valid && !req_stall, "result shown twice or block not idle after delivery")
   `R16_ASSERT_NOW(a_one_write_kind, rsp_valid, !(rsp_reg_written && rsp_mem_written), "item wrote both a register and memory")

endmodule
